// ===== design/pwod_pkg.sv =====
package pwod_pkg;

   localparam int CsrAddrWidth = 6;
   localparam int CsrDataWidth = 64;

   localparam logic [31:0] OutLimitsReset = 32'h00FF_0000;  // min 0, max 255
   localparam logic [31:0] ObsLimitsReset = 32'h00FF_FF01;  // min -255, max 255
   localparam logic [15:0] PeriodReset    = 16'd100;

   typedef enum logic [2:0] {
      REG_PROP_GAIN   = 3'd0,
      REG_INTEG_GAIN  = 3'd1,
      REG_DERIV_GAIN  = 3'd2,
      REG_OUT_LIMITS  = 3'd3,
      REG_OBS_LIMITS  = 3'd4,
      REG_PERIOD      = 3'd5,
      REG_ERR_MARGIN  = 3'd6,
      REG_OBS_SETTING = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] prop_gain;
      logic signed [15:0] integ_gain;
      logic signed [15:0] deriv_gain;
      logic [31:0]        output_limits;
      logic [31:0]        obstructed_limits;
      logic [15:0]        sample_period_ms;
      logic [15:0]        error_margin;
      logic [48:0]        obstruction_settings;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] angle;
      logic signed [15:0] velocity;
      logic signed [15:0] setpoint;
      logic [31:0]        now_ms;
      logic               auto_mode;
      logic signed [15:0] held_output;
   } item_type;

   typedef struct packed {
      logic signed [15:0] drive;
      logic               updated;
      logic               obstructed;
   } result_type;

   function automatic logic [16:0] abs17(input logic signed [16:0] v);
      abs17 = v[16] ? 17'(-v) : 17'(v);
   endfunction

   // max tested first, then min; inverted limits follow that order
   function automatic logic signed [15:0] clamp16(input logic signed [35:0] v,
                                                  input logic [31:0] lim);
      logic signed [15:0] lo;
      logic signed [15:0] hi;
      lo = signed'(lim[15:0]);
      hi = signed'(lim[31:16]);
      if (v > 36'(hi)) begin
         clamp16 = hi;
      end else if (v < 36'(lo)) begin
         clamp16 = lo;
      end else begin
         clamp16 = v[15:0];
      end
   endfunction

endpackage

// ===== design/pwod_req_if.sv =====
interface pwod_req_if;
   import pwod_pkg::*;
   logic     valid;
   logic     ready;
   item_type item;
   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

// ===== design/pwod_rsp_if.sv =====
interface pwod_rsp_if;
   import pwod_pkg::*;
   logic               valid;
   logic               ready;
   logic signed [15:0] drive;
   logic               updated;
   logic               obstructed;
   modport source (output valid, output drive, output updated, output obstructed,
                   input ready);
   modport sink (input valid, input drive, input updated, input obstructed,
                 output ready);
endinterface

// ===== design/pwod_core.sv =====
module pwod_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  pwod_pkg::cfg_type    cfg,
   input  pwod_pkg::item_type   item,
   output pwod_pkg::result_type result
);
   import pwod_pkg::*;

   logic signed [15:0] integral_ff, integral_in;
   logic signed [15:0] last_angle_ff, last_angle_in;
   logic signed [15:0] last_drive_ff, last_drive_in;
   logic [31:0]        last_ms_ff, last_ms_in;
   logic               time_valid_ff, time_valid_in;
   logic [31:0]        obs_ms_ff, obs_ms_in;
   logic               obs_flag_ff, obs_flag_in;
   logic               was_auto_ff;

   logic               rise;
   logic signed [15:0] integ0;
   logic signed [15:0] angle0;
   logic               enable;
   logic [31:0]        elapsed;
   logic               candidate;
   logic [32:0]        obs_sum;
   logic [31:0]        obs_sat;
   logic               compute;
   logic signed [16:0] err_raw;
   logic signed [16:0] err;
   logic signed [16:0] d_in;
   logic signed [32:0] prod_i;
   logic signed [32:0] prod_p;
   logic signed [32:0] prod_d;
   logic signed [15:0] integ_new;
   logic signed [35:0] drv_sum;
   logic signed [15:0] drv_obs;
   logic signed [15:0] drv_final;

   assign rise   = item.auto_mode && !was_auto_ff;
   assign integ0 = rise ? clamp16(36'(item.held_output), cfg.output_limits) : integral_ff;
   assign angle0 = rise ? item.angle : last_angle_ff;
   assign enable = cfg.obstruction_settings[0];

   assign elapsed = time_valid_ff ? (item.now_ms - last_ms_ff)
                                  : {16'd0, cfg.sample_period_ms};

   assign candidate = (abs17(17'(item.velocity)) <= {1'b0, cfg.obstruction_settings[16:1]})
                   && (abs17(17'(item.angle) - 17'(item.setpoint))
                        > {1'b0, cfg.obstruction_settings[32:17]})
                   && (last_drive_ff != '0);
   assign obs_sum   = {1'b0, obs_ms_ff} + {1'b0, elapsed};
   assign obs_sat   = obs_sum[32] ? '1 : obs_sum[31:0];

   assign compute = !time_valid_ff || (elapsed >= {16'd0, cfg.sample_period_ms});

   assign err_raw = 17'(item.setpoint) - 17'(item.angle);
   assign err     = (abs17(err_raw) < {1'b0, cfg.error_margin}) ? '0 : err_raw;
   assign d_in    = 17'(item.angle) - 17'(angle0);

   // three independent products, summed below
   assign prod_i = 33'(cfg.integ_gain) * 33'(err);
   assign prod_p = 33'(cfg.prop_gain) * 33'(err);
   assign prod_d = 33'(cfg.deriv_gain) * 33'(d_in);

   assign integ_new = clamp16(36'(integ0) + 36'(prod_i), cfg.output_limits);
   assign drv_sum   = 36'(prod_p) + 36'(integ_new) - 36'(prod_d);
   assign drv_obs   = obs_flag_in ? clamp16(drv_sum, cfg.obstructed_limits)
                                  : clamp16(drv_sum, 32'h7FFF_8000);
   assign drv_final = clamp16(36'(drv_obs), cfg.output_limits);

   always_comb begin
      integral_in   = integ0;
      last_angle_in = angle0;
      last_drive_in = last_drive_ff;
      last_ms_in    = last_ms_ff;
      time_valid_in = time_valid_ff;
      obs_ms_in     = obs_ms_ff;
      obs_flag_in   = obs_flag_ff;
      if (item.auto_mode) begin
         if (enable && candidate) begin
            obs_ms_in   = obs_sat;
            obs_flag_in = obs_sat >= {16'd0, cfg.obstruction_settings[48:33]};
         end else begin
            obs_ms_in   = '0;
            obs_flag_in = 1'b0;
         end
         if (compute) begin
            integral_in   = integ_new;
            last_angle_in = item.angle;
            last_drive_in = drv_final;
            last_ms_in    = item.now_ms;
            time_valid_in = 1'b1;
         end
      end
   end

   assign result.drive      = last_drive_in;
   assign result.updated    = item.auto_mode && compute;
   assign result.obstructed = obs_flag_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff   <= '0;
         last_angle_ff <= '0;
         last_drive_ff <= '0;
         last_ms_ff    <= '0;
         time_valid_ff <= 1'b0;
         obs_ms_ff     <= '0;
         obs_flag_ff   <= 1'b0;
         was_auto_ff   <= 1'b0;
      end else if (step) begin
         integral_ff   <= integral_in;
         last_angle_ff <= last_angle_in;
         last_drive_ff <= last_drive_in;
         last_ms_ff    <= last_ms_in;
         time_valid_ff <= time_valid_in;
         obs_ms_ff     <= obs_ms_in;
         obs_flag_ff   <= obs_flag_in;
         was_auto_ff   <= item.auto_mode;
      end
   end

endmodule

// ===== design/pid_with_obstruction_detect_top.sv =====
// PID controller with obstruction detection, one result per input transfer.
// Path from input transfer to result valid: input register, then result
// register; throughput one transfer per cycle while results are taken, set by
// the single-pass update of the controller state between those two registers.
// Reset (synchronous, active high): controller state and flags clear, the
// registers return to their defaults, both pipeline stages empty.
module pid_with_obstruction_detect_top (
   input  logic                                 clock,
   input  logic                                 reset,
   pwod_req_if.sink                             req_ch,
   pwod_rsp_if.source                           rsp_ch,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [pwod_pkg::CsrAddrWidth-1:0]    paddr,
   input  logic [pwod_pkg::CsrDataWidth-1:0]    pwdata,
   output logic [pwod_pkg::CsrDataWidth-1:0]    prdata,
   output logic                                 pready
);
   import pwod_pkg::*;

   // ---------------- register file ----------------
   cfg_type       cfg_ff;
   csr_index_type csr_idx;
   logic          csr_write;

   assign pready    = 1'b1;
   assign csr_idx   = csr_index_type'(paddr[CsrAddrWidth-1:3]);  // 8-byte stride
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain            <= '0;
         cfg_ff.integ_gain           <= '0;
         cfg_ff.deriv_gain           <= '0;
         cfg_ff.output_limits        <= OutLimitsReset;
         cfg_ff.obstructed_limits    <= ObsLimitsReset;
         cfg_ff.sample_period_ms     <= PeriodReset;
         cfg_ff.error_margin         <= '0;
         cfg_ff.obstruction_settings <= '0;
      end else if (csr_write) begin
         case (csr_idx)
            REG_PROP_GAIN:   cfg_ff.prop_gain            <= pwdata[15:0];
            REG_INTEG_GAIN:  cfg_ff.integ_gain           <= pwdata[15:0];
            REG_DERIV_GAIN:  cfg_ff.deriv_gain           <= pwdata[15:0];
            REG_OUT_LIMITS:  cfg_ff.output_limits        <= pwdata[31:0];
            REG_OBS_LIMITS:  cfg_ff.obstructed_limits    <= pwdata[31:0];
            REG_PERIOD:      cfg_ff.sample_period_ms     <= pwdata[15:0];
            REG_ERR_MARGIN:  cfg_ff.error_margin         <= pwdata[15:0];
            REG_OBS_SETTING: cfg_ff.obstruction_settings <= pwdata[48:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_PROP_GAIN:   prdata = {48'd0, cfg_ff.prop_gain};
         REG_INTEG_GAIN:  prdata = {48'd0, cfg_ff.integ_gain};
         REG_DERIV_GAIN:  prdata = {48'd0, cfg_ff.deriv_gain};
         REG_OUT_LIMITS:  prdata = {32'd0, cfg_ff.output_limits};
         REG_OBS_LIMITS:  prdata = {32'd0, cfg_ff.obstructed_limits};
         REG_PERIOD:      prdata = {48'd0, cfg_ff.sample_period_ms};
         REG_ERR_MARGIN:  prdata = {48'd0, cfg_ff.error_margin};
         REG_OBS_SETTING: prdata = {15'd0, cfg_ff.obstruction_settings};
         default:         prdata = '0;
      endcase
   end

   // ---------------- two-stage pipeline ----------------
   // Stage 1 holds the accepted transfer; the core updates state as the item
   // moves into the result register. Stage 1 takes a transfer when it is empty
   // or its item moves on; stage 2 loads when it is empty or its result is
   // taken. A waiting result stalls intake only once stage 1 also holds an item.
   logic       in_valid_ff;
   item_type   item_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;
   result_type core_res;
   logic       advance;
   logic       step;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign step         = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;

   pwod_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .cfg    (cfg_ff),
      .item   (item_ff),
      .result (core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         item_ff <= req_ch.item;
      end
      if (step) begin
         rsp_ff <= core_res;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.drive      = rsp_ff.drive;
   assign rsp_ch.updated    = rsp_ff.updated;
   assign rsp_ch.obstructed = rsp_ff.obstructed;

   // ---------------- checks ----------------
   // a compute only ever happens on an auto-mode item
   a_update_needs_auto: assert property (@(posedge clock) disable iff (reset)
      step && core_res.updated |-> item_ff.auto_mode)
      else $error("compute flagged on a manual item");

   // with detection off, an auto item always leaves the flag clear
   a_no_flag_when_off: assert property (@(posedge clock) disable iff (reset)
      step && item_ff.auto_mode && !cfg_ff.obstruction_settings[0]
      |-> !core_res.obstructed)
      else $error("obstruction flag set while detection disabled");

   // an empty result stage never stalls intake
   a_intake_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ch.ready)
      else $error("input stalled with empty result stage");

   // a held item in stage 1 is not dropped while the output is stalled
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("pending item lost during stall");

endmodule

// ===== bench/pwod_drive_checker.sv =====
module pwod_drive_checker (
   input  logic                              clock,
   input  logic                              reset,
   pwod_req_if                               req_mon,
   pwod_rsp_if                               rsp_mon,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic                              pready,
   input  logic [pwod_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [pwod_pkg::CsrDataWidth-1:0] pwdata,
   output int                                fail_count,
   output int                                pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import pwod_pkg::*;

   cfg_type            regs;
   logic signed [15:0] integ_acc;
   logic signed [15:0] prev_angle;
   logic signed [15:0] prev_drive;
   logic [31:0]        last_ms;
   logic               have_time;
   logic [31:0]        stall_ms;
   logic               stall_flag;
   logic               auto_prev;
   result_type         expected_drives[$];

   function automatic longint magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // upper bound checked first, so swapped bounds follow the same order
   function automatic logic signed [15:0] limit16(longint v, logic [31:0] lim);
      longint lo;
      longint hi;
      lo = longint'($signed(lim[15:0]));
      hi = longint'($signed(lim[31:16]));
      if (v > hi) return 16'(hi);
      if (v < lo) return 16'(lo);
      return 16'(v);
   endfunction

   function automatic result_type next_drive(item_type s);
      result_type  r;
      longint      ang;
      longint      vel;
      longint      sp;
      longint      err;
      longint      dmeas;
      longint      drv;
      logic [31:0] elapsed;
      logic [31:0] acc;
      logic        det_on;
      logic        fresh;
      ang   = longint'($signed(s.angle));
      vel   = longint'($signed(s.velocity));
      sp    = longint'($signed(s.setpoint));
      fresh = 1'b0;
      if (s.auto_mode && !auto_prev) begin
         integ_acc  = limit16(longint'($signed(s.held_output)), regs.output_limits);
         prev_angle = s.angle;
      end
      auto_prev = s.auto_mode;
      if (s.auto_mode) begin
         det_on  = regs.obstruction_settings[0];
         elapsed = have_time ? s.now_ms - last_ms : 32'(regs.sample_period_ms);
         if (det_on && magnitude(vel) <= longint'(regs.obstruction_settings[16:1])
             && magnitude(ang - sp) > longint'(regs.obstruction_settings[32:17])
             && prev_drive != 0) begin
            acc        = stall_ms + elapsed;
            stall_ms   = (acc < stall_ms) ? 32'hFFFF_FFFF : acc;
            stall_flag = stall_ms >= 32'(regs.obstruction_settings[48:33]);
         end else begin
            stall_ms   = '0;
            stall_flag = 1'b0;
         end
         if (!have_time || elapsed >= 32'(regs.sample_period_ms)) begin
            err = sp - ang;
            if (magnitude(err) < longint'(regs.error_margin)) err = 0;
            integ_acc = limit16(longint'(integ_acc)
                                + longint'($signed(regs.integ_gain)) * err,
                                regs.output_limits);
            dmeas = ang - longint'(prev_angle);
            drv   = longint'($signed(regs.prop_gain)) * err + longint'(integ_acc)
                    - longint'($signed(regs.deriv_gain)) * dmeas;
            if (stall_flag && det_on) drv = longint'(limit16(drv, regs.obstructed_limits));
            prev_drive = limit16(drv, regs.output_limits);
            prev_angle = s.angle;
            last_ms    = s.now_ms;
            have_time  = 1'b1;
            fresh      = 1'b1;
         end
      end
      r.drive      = prev_drive;
      r.updated    = fresh;
      r.obstructed = stall_flag;
      return r;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         regs                      = '0;
         regs.output_limits        = OutLimitsReset;
         regs.obstructed_limits    = ObsLimitsReset;
         regs.sample_period_ms     = PeriodReset;
         integ_acc                 = '0;
         prev_angle                = '0;
         prev_drive                = '0;
         last_ms                   = '0;
         have_time                 = 1'b0;
         stall_ms                  = '0;
         stall_flag                = 1'b0;
         auto_prev                 = 1'b0;
         fail_count                = 0;
         expected_drives.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (csr_index_type'(paddr[CsrAddrWidth-1:3]))
               REG_PROP_GAIN:   regs.prop_gain            = pwdata[15:0];
               REG_INTEG_GAIN:  regs.integ_gain           = pwdata[15:0];
               REG_DERIV_GAIN:  regs.deriv_gain           = pwdata[15:0];
               REG_OUT_LIMITS:  regs.output_limits        = pwdata[31:0];
               REG_OBS_LIMITS:  regs.obstructed_limits    = pwdata[31:0];
               REG_PERIOD:      regs.sample_period_ms     = pwdata[15:0];
               REG_ERR_MARGIN:  regs.error_margin         = pwdata[15:0];
               REG_OBS_SETTING: regs.obstruction_settings = pwdata[48:0];
               default: ;
            endcase
         end
         // a result never leaves in the cycle its input arrives, so pop first
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_drives.size() == 0) begin
               $error("unexpected result transfer: drive %0d", rsp_mon.drive);
               fail_count++;
            end else begin
               want = expected_drives.pop_front();
               if (rsp_mon.drive !== want.drive) begin
                  $error("drive expected %0d actual %0d", want.drive, rsp_mon.drive);
                  fail_count++;
               end
               if (rsp_mon.updated !== want.updated) begin
                  $error("updated expected %0b actual %0b", want.updated, rsp_mon.updated);
                  fail_count++;
               end
               if (rsp_mon.obstructed !== want.obstructed) begin
                  $error("obstructed expected %0b actual %0b",
                         want.obstructed, rsp_mon.obstructed);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) expected_drives.push_back(next_drive(req_mon.item));
      end
      pending = expected_drives.size();
   end

endmodule

// ===== bench/pid_with_obstruction_detect_top_tb.sv =====
module pid_with_obstruction_detect_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pwod_pkg::*;

   // cycles without any transfer before the run is declared hung; covers the
   // long receiver hold-off plus drain and register writes many times over
   localparam int IdleLimit = 3000;
   // response count at which the receiver stops taking results for a while
   localparam int HoldAt    = 520;
   localparam int HoldLen   = 80;

   logic                    clock;
   logic                    reset;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CsrAddrWidth-1:0] paddr;
   logic [CsrDataWidth-1:0] pwdata;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;
   int                      fail_count;
   int                      pending;

   // percent of cycles each side idles; changed only between phases
   int                      send_gap_pct;
   int                      take_gap_pct;

   // generator state: running millisecond clock and the thresholds in force,
   // used to aim samples near the obstruction boundaries
   logic [31:0]             clock_ms;
   int                      gen_period;
   int                      gen_vth;
   int                      gen_ath;

   pwod_req_if req_bus ();
   pwod_rsp_if rsp_bus ();

   pid_with_obstruction_detect_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_bus),
      .rsp_ch  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // prediction and comparison live in the checker; this module only drives
   pwod_drive_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // limits word: min in the low half, max in the high half
   function automatic logic [31:0] limits(int lo, int hi);
      return {16'(hi), 16'(lo)};
   endfunction

   // obstruction settings word: enable, velocity, angle and time thresholds
   function automatic logic [48:0] obs_word(bit en, int vth, int ath, int tth);
      return {16'(tth), 16'(ath), 16'(vth), en};
   endfunction

   // APB write: setup cycle, then access cycle until pready; the caller
   // drops psel once its last write is done
   task automatic csr_write(csr_index_type idx, logic [CsrDataWidth-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   // every register gets written on each setup change
   task automatic apply_setup(logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
                              logic [31:0] out_lim, logic [31:0] obs_lim,
                              logic [15:0] period, logic [15:0] margin,
                              logic [48:0] obs_set);
      csr_write(REG_PROP_GAIN,   64'(kp));
      csr_write(REG_INTEG_GAIN,  64'(ki));
      csr_write(REG_DERIV_GAIN,  64'(kd));
      csr_write(REG_OUT_LIMITS,  64'(out_lim));
      csr_write(REG_OBS_LIMITS,  64'(obs_lim));
      csr_write(REG_PERIOD,      64'(period));
      csr_write(REG_ERR_MARGIN,  64'(margin));
      csr_write(REG_OBS_SETTING, 64'(obs_set));
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      gen_period = int'(period);
      gen_vth    = int'(obs_set[16:1]);
      gen_ath    = int'(obs_set[32:17]);
   endtask

   // offer one item, with a random gap first; returns at the transfer edge
   // with valid still high, so back-to-back items never drop valid
   task automatic send_item(item_type s);
      while ($urandom_range(99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.item  <= s;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic send_sample(logic [31:0] now, bit auto_on, int ang, int vel,
                              int sp, int held);
      item_type s;
      s.now_ms      = now;
      s.auto_mode   = auto_on;
      s.angle       = 16'(ang);
      s.velocity    = 16'(vel);
      s.setpoint    = 16'(sp);
      s.held_output = 16'(held);
      send_item(s);
   endtask

   // quiesce before touching registers: every result back, then an idle
   // wait to cover the two-stage pipeline
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   // mostly plausible control traffic: time advancing around the sample
   // period, angles and velocities near the obstruction thresholds, auto on;
   // the rest is time jumps, arbitrary samples and manual items
   function automatic item_type random_sample();
      item_type s;
      int unsigned pick;
      int          off;
      pick = $urandom_range(99);
      if (pick < 70) clock_ms += $urandom_range(2 * gen_period + 2);
      else if (pick < 90) clock_ms += $urandom_range(3);
      else clock_ms = $urandom();
      s.now_ms      = clock_ms;
      s.auto_mode   = ($urandom_range(99) >= 5);
      s.setpoint    = 16'($urandom());
      off           = int'($urandom_range(2 * (gen_ath + 64))) - (gen_ath + 64);
      s.angle       = ($urandom_range(99) < 60) ? 16'(int'(s.setpoint) + off)
                                                : 16'($urandom());
      off           = int'($urandom_range(2 * (gen_vth + 8))) - (gen_vth + 8);
      s.velocity    = ($urandom_range(99) < 60) ? 16'(off) : 16'($urandom());
      s.held_output = 16'($urandom());
      return s;
   endfunction

   task automatic run_random(int count);
      repeat (count) send_item(random_sample());
      drain();
   endtask

   // receiver: random stalls, plus one long hold-off so the pipeline fills
   // and the input side has to stall
   initial begin
      int taken;
      int hold_left;
      bit held;
      taken     = 0;
      hold_left = 0;
      held      = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) taken++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!held && taken >= HoldAt) begin
            held      = 1'b1;
            hold_left = HoldLen;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= take_gap_pct);
         end
      end
   end

   // watchdog: any transfer on either channel or the register port resets it
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < IdleLimit) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || psel)
            quiet = 0;
         else
            quiet++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      send_gap_pct = 20;
      take_gap_pct = 47;
      clock_ms     = '0;
      gen_period   = int'(PeriodReset);
      gen_vth      = 0;
      gen_ath      = 0;
      reset        <= 1'b1;
      psel         <= 1'b0;
      penable      <= 1'b0;
      pwrite       <= 1'b0;
      paddr        <= '0;
      pwdata       <= '0;
      req_bus.valid <= 1'b0;
      req_bus.item  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, part one: detection on with small thresholds
      apply_setup(16'd2, 16'd1, 16'd1, limits(-500, 500), limits(-50, 50),
                  16'd10, 16'd2, obs_word(1'b1, 10, 20, 15));
      send_sample(32'd0, 1'b0, 1234, 0, -50, 77);        // manual: state held
      send_sample(32'd5, 1'b1, 0, 0, 100, 32767);        // rising auto, first compute
      send_sample(32'd8, 1'b1, 0, 0, 100, 0);            // candidate, under time
      send_sample(32'd20, 1'b1, 0, -10, 100, 0);         // flag sets, obstructed clamp
      send_sample(32'd20, 1'b1, 101, 10, 100, 0);        // velocity at its threshold
      send_sample(32'd40, 1'b1, 99, 3, 100, 0);          // error inside the margin
      send_sample(32'hFFFF_FFF0, 1'b1, -32768, -10, 32767, -32768);
      send_sample(32'hFFFF_FFEF, 1'b1, -32768, -10, 32767, 0);  // stall time saturates
      send_sample(32'hFFFF_FFFF, 1'b1, 32767, 32767, -32768, 0);
      send_sample(32'd0, 1'b1, 32767, -32768, -32768, 0); // now wraps
      send_sample(32'd3, 1'b0, 0, 0, 0, -32768);
      send_sample(32'd4, 1'b1, -100, 5, 200, -32768);    // re-entry seeds from held
      send_sample(32'd30, 1'b1, -100, 0, 200, 32767);
      send_sample(32'd31, 1'b1, 500, -1, 0, 0);
      send_sample(32'd100, 1'b1, 0, 1, 0, -1);
      drain();

      // directed, part two: zero period, swapped output limits, detection off
      // with all threshold bits set
      apply_setup(16'h8000, 16'h7FFF, 16'h8000, limits(100, -100), limits(0, 0),
                  16'd0, 16'd0, obs_word(1'b0, 65535, 65535, 65535));
      send_sample(32'd100, 1'b0, 0, 0, 0, 0);
      send_sample(32'd100, 1'b1, 50, 0, -50, 12345);
      send_sample(32'd100, 1'b1, 50, 0, -50, 0);         // same time, still computes
      send_sample(32'd100, 1'b1, -32768, 32767, 32767, 0);
      send_sample(32'd7, 1'b1, 32767, -32768, -32768, -1);
      send_sample(32'd7, 1'b0, 0, 0, 0, 0);
      send_sample(32'd7, 1'b1, 0, 0, 0, -32768);
      drain();

      // random phases, sender lighter than receiver
      apply_setup(16'd4, 16'd1, 16'd2, limits(-1000, 1000), limits(-100, 100),
                  16'd10, 16'd3, obs_word(1'b1, 20, 50, 30));
      run_random(105);
      apply_setup(16'h7FFF, 16'h8000, 16'h7FFF, limits(-32768, 32767), limits(200, -200),
                  16'd1, 16'hFFFF, obs_word(1'b1, 65535, 0, 0));
      run_random(105);

      // swap who idles more
      send_gap_pct = 47;
      take_gap_pct = 20;
      apply_setup(16'($urandom()), 16'($urandom()), 16'($urandom()), $urandom(), $urandom(),
                  16'($urandom_range(1, 40)), 16'($urandom_range(300)),
                  obs_word(1'b1, $urandom_range(2000), $urandom_range(2000),
                           $urandom_range(200)));
      run_random(105);
      apply_setup(16'($urandom_range(31) - 16), 16'($urandom_range(7) - 4), 16'd0,
                  OutLimitsReset, ObsLimitsReset, 16'hFFFF, 16'd0,
                  obs_word(1'b1, 65535, 65535, 65535));
      run_random(105);

      // no idling; the receiver hold-off falls in here
      send_gap_pct = 0;
      take_gap_pct = 0;
      apply_setup(16'($urandom()), 16'($urandom()), 16'($urandom()), $urandom(), $urandom(),
                  16'($urandom_range(20)), 16'($urandom_range(50)),
                  49'({$urandom(), $urandom()}));
      run_random(105);
      apply_setup(16'hFFFF, 16'd0, 16'd0, limits(-32768, 32767), limits(-10, 10),
                  16'd5, 16'd1, obs_word(1'b1, 5, 0, 3));
      run_random(105);

      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/pwod_pkg.sv
design/pwod_req_if.sv
design/pwod_rsp_if.sv
design/pwod_core.sv
design/pid_with_obstruction_detect_top.sv
bench/pwod_drive_checker.sv
bench/pid_with_obstruction_detect_top_tb.sv
